FILE: sv/tsr_pkg.sv
// Package with the shared types, constants and widths of the triangle span rasterizer.
`default_nettype none
package tsr_pkg;
   localparam int COORD_BITS_DEFAULT = 12;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT0,
      ST_SORT1,
      ST_SORT2,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_SETUP,
      ST_EMIT,
      ST_WALK1,
      ST_WALK2,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_FIRST = 2'd1,
      PH_FINAL = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      PART_FLAT_BOTTOM,
      PART_FLAT_TOP,
      PART_SPLIT_FIRST,
      PART_SPLIT_SECOND
   } part_type;

   typedef struct packed {
      logic     capture;
      logic     sort_ab;
      logic     sort_ac;
      logic     sort_bc;
      logic     div_start;
      logic     setup;
      part_type part;
      logic     emit;
      logic     walk1;
      logic     walk2;
      logic     clear_out;
   } cmd_type;

   typedef struct packed {
      logic flat_bottom;
      logic flat_top;
      logic div_busy;
      logic part_end;
      logic synced;
   } status_type;
endpackage
`default_nettype wire

FILE: sv/tsr_if.sv
// Valid/ready channel interfaces for the request and response transfers.
`default_nettype none
interface tsr_req_if #(parameter int COORD_BITS = 12);
   logic valid;
   logic ready;
   logic mode;
   logic signed [COORD_BITS-1:0] vertex_a_x;
   logic signed [COORD_BITS-1:0] vertex_a_y;
   logic signed [COORD_BITS-1:0] vertex_b_x;
   logic signed [COORD_BITS-1:0] vertex_b_y;
   logic signed [COORD_BITS-1:0] vertex_c_x;
   logic signed [COORD_BITS-1:0] vertex_c_y;
   modport source (output valid, mode, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                   vertex_c_x, vertex_c_y, input ready);
   modport sink (input valid, mode, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                 vertex_c_x, vertex_c_y, output ready);
endinterface

interface tsr_rsp_if #(parameter int COORD_BITS = 12);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] span_y;
   logic signed [COORD_BITS-1:0] span_x_start;
   logic signed [COORD_BITS-1:0] span_x_end;
   logic span_valid;
   logic span_last;
   modport source (output valid, span_y, span_x_start, span_x_end, span_valid, span_last,
                   input ready);
   modport sink (input valid, span_y, span_x_start, span_x_end, span_valid, span_last,
                 output ready);
endinterface
`default_nettype wire

FILE: sv/tsr_divider.sv
// Restoring signed divider that truncates toward zero, one quotient bit per cycle.
`default_nettype none
module tsr_divider #(
   parameter int NUM_BITS = 26,
   parameter int DEN_BITS = 13
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire signed [NUM_BITS-1:0]  numerator,
   input  wire signed [DEN_BITS-1:0]  denominator,
   output logic                       busy,
   output logic signed [NUM_BITS-1:0] quotient
);
   localparam int CW = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic                busy_ff, busy_in;
   logic [DEN_BITS:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DEN_BITS-1:0], quo_ff[NUM_BITS-1]};
      if (start) begin
         quo_in  = numerator[NUM_BITS-1] ? NUM_BITS'(-numerator) : NUM_BITS'(numerator);
         den_in  = denominator[DEN_BITS-1] ? DEN_BITS'(-denominator)
                                           : DEN_BITS'(denominator);
         rem_in  = '0;
         cnt_in  = CW'(NUM_BITS);
         neg_in  = numerator[NUM_BITS-1] ^ denominator[DEN_BITS-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule
`default_nettype wire

FILE: sv/tsr_datapath.sv
// Datapath: vertex sort, split point, edge setup and Bresenham edge walks.
`default_nettype none
module tsr_datapath #(
   parameter int COORD_BITS = tsr_pkg::COORD_BITS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  tsr_pkg::cmd_type              cmd,
   output tsr_pkg::status_type           status,
   input  wire signed [COORD_BITS-1:0]   in_ax,
   input  wire signed [COORD_BITS-1:0]   in_ay,
   input  wire signed [COORD_BITS-1:0]   in_bx,
   input  wire signed [COORD_BITS-1:0]   in_by,
   input  wire signed [COORD_BITS-1:0]   in_cx,
   input  wire signed [COORD_BITS-1:0]   in_cy,
   output logic signed [COORD_BITS-1:0]  out_y,
   output logic signed [COORD_BITS-1:0]  out_xs,
   output logic signed [COORD_BITS-1:0]  out_xe
);
   import tsr_pkg::*;

   localparam int W  = COORD_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 3;
   localparam int NW = 2 * COORD_BITS + 2;

   logic signed [W-1:0] v_ff [6];
   logic signed [W-1:0] v_in [6];
   logic signed [W-1:0] split_ff;
   logic signed [W-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   logic signed [W-1:0] p1x_in, p1y_in, p2x_in, p2y_in;
   logic [DW-1:0] maj1_ff, mnr1_ff, maj2_ff, mnr2_ff;
   logic [DW-1:0] maj1_in, mnr1_in, maj2_in, mnr2_in;
   logic signed [EW-1:0] e1_ff, e2_ff, e1_in, e2_in;
   logic signed [1:0] sx1_ff, sy1_ff, sx2_ff, sy2_ff;
   logic signed [1:0] sx1_in, sy1_in, sx2_in, sy2_in;
   logic sw1_ff, sw2_ff, sw1_in, sw2_in;
   logic [DW-1:0] cnt_ff, cnt_in;

   logic signed [W-1:0] ax, ay, bx, by, cx, cy;
   logic signed [DW-1:0] d1x, d1y, d2x, d2y;
   logic [DW-1:0] a1x, a1y, a2x, a2y;
   logic signed [DW-1:0] den;
   logic signed [NW-1:0] num;
   logic signed [NW-1:0] quo;
   logic div_busy;

   function automatic logic signed [1:0] sgn(input logic signed [DW-1:0] d);
      sgn = (d > 0) ? 2'sd1 : ((d < 0) ? -2'sd1 : 2'sd0);
   endfunction

   assign den = DW'(v_ff[5]) - DW'(v_ff[1]);
   assign num = NW'(v_ff[0]) * NW'(den)
              + NW'(DW'(v_ff[3]) - DW'(v_ff[1])) * NW'(DW'(v_ff[4]) - DW'(v_ff[0]));

   tsr_divider #(.NUM_BITS(NW), .DEN_BITS(DW)) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .numerator   (num),
      .denominator (den),
      .busy        (div_busy),
      .quotient    (quo)
   );

   always_comb begin
      case (cmd.part)
         PART_FLAT_TOP: begin
            ax = v_ff[4]; ay = v_ff[5]; bx = v_ff[0]; by = v_ff[1]; cx = v_ff[2]; cy = v_ff[3];
         end
         PART_SPLIT_FIRST: begin
            ax = v_ff[0]; ay = v_ff[1]; bx = v_ff[2]; by = v_ff[3]; cx = quo[W-1:0];
            cy = v_ff[3];
         end
         PART_SPLIT_SECOND: begin
            ax = v_ff[4]; ay = v_ff[5]; bx = v_ff[2]; by = v_ff[3]; cx = split_ff; cy = v_ff[3];
         end
         default: begin
            ax = v_ff[0]; ay = v_ff[1]; bx = v_ff[2]; by = v_ff[3]; cx = v_ff[4]; cy = v_ff[5];
         end
      endcase
      d1x = DW'(bx) - DW'(ax);
      d1y = DW'(by) - DW'(ay);
      d2x = DW'(cx) - DW'(ax);
      d2y = DW'(cy) - DW'(ay);
      a1x = d1x[DW-1] ? DW'(-d1x) : DW'(d1x);
      a1y = d1y[DW-1] ? DW'(-d1y) : DW'(d1y);
      a2x = d2x[DW-1] ? DW'(-d2x) : DW'(d2x);
      a2y = d2y[DW-1] ? DW'(-d2y) : DW'(d2y);
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         v_in[i] = v_ff[i];
      end
      p1x_in = p1x_ff; p1y_in = p1y_ff; p2x_in = p2x_ff; p2y_in = p2y_ff;
      maj1_in = maj1_ff; mnr1_in = mnr1_ff; maj2_in = maj2_ff; mnr2_in = mnr2_ff;
      e1_in = e1_ff; e2_in = e2_ff;
      sx1_in = sx1_ff; sy1_in = sy1_ff; sx2_in = sx2_ff; sy2_in = sy2_ff;
      sw1_in = sw1_ff; sw2_in = sw2_ff;
      cnt_in = cnt_ff;
      if (cmd.capture) begin
         v_in[0] = in_ax; v_in[1] = in_ay; v_in[2] = in_bx;
         v_in[3] = in_by; v_in[4] = in_cx; v_in[5] = in_cy;
      end else if (cmd.sort_ab && v_ff[1] > v_ff[3]) begin
         v_in[0] = v_ff[2]; v_in[1] = v_ff[3]; v_in[2] = v_ff[0]; v_in[3] = v_ff[1];
      end else if (cmd.sort_ac && v_ff[1] > v_ff[5]) begin
         v_in[0] = v_ff[4]; v_in[1] = v_ff[5]; v_in[4] = v_ff[0]; v_in[5] = v_ff[1];
      end else if (cmd.sort_bc && v_ff[3] > v_ff[5]) begin
         v_in[2] = v_ff[4]; v_in[3] = v_ff[5]; v_in[4] = v_ff[2]; v_in[5] = v_ff[3];
      end
      if (cmd.setup) begin
         p1x_in = ax; p1y_in = ay; p2x_in = ax; p2y_in = ay;
         sw1_in = a1y > a1x;
         maj1_in = sw1_in ? a1y : a1x;
         mnr1_in = sw1_in ? a1x : a1y;
         sw2_in = a2y > a2x;
         maj2_in = sw2_in ? a2y : a2x;
         mnr2_in = sw2_in ? a2x : a2y;
         e1_in = EW'({mnr1_in, 1'b0}) - EW'(maj1_in);
         e2_in = EW'({mnr2_in, 1'b0}) - EW'(maj2_in);
         sx1_in = sgn(d1x); sy1_in = sgn(d1y);
         sx2_in = sgn(d2x); sy2_in = sgn(d2y);
         cnt_in = '0;
      end
      if (cmd.walk1) begin
         e1_in = e1_ff + EW'({mnr1_ff, 1'b0});
         if (!e1_ff[EW-1]) begin
            e1_in = e1_in - EW'({maj1_ff, 1'b0});
            if (sw1_ff) begin
               p1x_in = p1x_ff + W'(sx1_ff);
            end else begin
               p1y_in = p1y_ff + W'(sy1_ff);
            end
         end
         if (sw1_ff) begin
            p1y_in = p1y_in + W'(sy1_ff);
         end else begin
            p1x_in = p1x_in + W'(sx1_ff);
         end
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.walk2) begin
         e2_in = e2_ff + EW'({mnr2_ff, 1'b0});
         if (!e2_ff[EW-1]) begin
            e2_in = e2_in - EW'({maj2_ff, 1'b0});
            if (sw2_ff) begin
               p2x_in = p2x_ff + W'(sx2_ff);
            end else begin
               p2y_in = p2y_ff + W'(sy2_ff);
            end
         end
         if (sw2_ff) begin
            p2y_in = p2y_in + W'(sy2_ff);
         end else begin
            p2x_in = p2x_in + W'(sx2_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            v_ff[i] <= '0;
         end
         split_ff <= '0;
         p1x_ff <= '0; p1y_ff <= '0; p2x_ff <= '0; p2y_ff <= '0;
         maj1_ff <= '0; mnr1_ff <= '0; maj2_ff <= '0; mnr2_ff <= '0;
         e1_ff <= '0; e2_ff <= '0;
         sx1_ff <= '0; sy1_ff <= '0; sx2_ff <= '0; sy2_ff <= '0;
         sw1_ff <= 1'b0; sw2_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         for (int i = 0; i < 6; i++) begin
            v_ff[i] <= v_in[i];
         end
         if (cmd.capture) begin
            split_ff <= '0;
         end else if (cmd.setup && cmd.part == PART_SPLIT_FIRST) begin
            split_ff <= quo[W-1:0];
         end
         p1x_ff <= p1x_in; p1y_ff <= p1y_in; p2x_ff <= p2x_in; p2y_ff <= p2y_in;
         maj1_ff <= maj1_in; mnr1_ff <= mnr1_in; maj2_ff <= maj2_in; mnr2_ff <= mnr2_in;
         e1_ff <= e1_in; e2_ff <= e2_in;
         sx1_ff <= sx1_in; sy1_ff <= sy1_in; sx2_ff <= sx2_in; sy2_ff <= sy2_in;
         sw1_ff <= sw1_in; sw2_ff <= sw2_in;
         cnt_ff <= cnt_in;
      end
   end

   assign status.flat_bottom = (v_ff[3] == v_ff[5]);
   assign status.flat_top    = (v_ff[1] == v_ff[3]);
   assign status.div_busy    = div_busy;
   assign status.part_end    = (cnt_ff >= maj1_ff);
   assign status.synced      = (p2y_ff == p1y_ff);
   assign out_y  = p1y_ff;
   assign out_xs = p1x_ff;
   assign out_xe = p2x_ff;
endmodule
`default_nettype wire

FILE: sv/tsr_controller.sv
// Controller state machine that sequences load, setup, span output and edge walks.
`default_nettype none
module tsr_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_mode,
   output logic                 req_ready,
   output logic                 rsp_load,
   input  wire                  rsp_free,
   output logic                 rsp_span,
   output logic                 rsp_last,
   output tsr_pkg::cmd_type     cmd,
   input  tsr_pkg::status_type  status
);
   import tsr_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   part_type  part_ff, part_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         part_ff  <= PART_FLAT_BOTTOM;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         part_ff  <= part_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      part_in   = part_ff;
      cmd       = '0;
      cmd.part  = part_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      rsp_span  = 1'b0;
      rsp_last  = (phase_ff == PH_FINAL) && status.part_end;
      case (state_ff)
         ST_IDLE: begin
            req_ready = rsp_free;
            if (req_valid && rsp_free) begin
               if (!req_mode) begin
                  cmd.capture = 1'b1;
                  rsp_load    = 1'b1;
                  phase_in    = PH_IDLE;
                  state_in    = ST_SORT0;
               end else if (phase_ff == PH_IDLE) begin
                  rsp_load = 1'b1;
               end else begin
                  rsp_span = 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SORT0: begin
            cmd.sort_ab = 1'b1;
            state_in    = ST_SORT1;
         end
         ST_SORT1: begin
            cmd.sort_ac = 1'b1;
            state_in    = ST_SORT2;
         end
         ST_SORT2: begin
            cmd.sort_bc = 1'b1;
            state_in    = ST_DIV_START;
         end
         ST_DIV_START: begin
            if (status.flat_bottom) begin
               part_in  = PART_FLAT_BOTTOM;
               phase_in = PH_FINAL;
               state_in = ST_SETUP;
            end else if (status.flat_top) begin
               part_in  = PART_FLAT_TOP;
               phase_in = PH_FINAL;
               state_in = ST_SETUP;
            end else begin
               cmd.div_start = 1'b1;
               part_in  = PART_SPLIT_FIRST;
               phase_in = PH_FIRST;
               state_in = ST_DIV_RUN;
            end
         end
         ST_DIV_RUN: begin
            if (!status.div_busy) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_EMIT: begin
            if (status.part_end) begin
               if (phase_ff == PH_FIRST) begin
                  part_in  = PART_SPLIT_SECOND;
                  phase_in = PH_FINAL;
                  state_in = ST_SETUP;
               end else begin
                  phase_in = PH_IDLE;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.walk1 = 1'b1;
               state_in  = ST_WALK2;
            end
         end
         ST_WALK2: begin
            if (status.synced) begin
               state_in = ST_IDLE;
            end else begin
               cmd.walk2 = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

FILE: sv/triangle_span_rasterizer_core.sv
// Top level of the triangle span rasterizer: controller, datapath and response register.
// A load passes through the sort, divide-start and setup states, with the split divide
// when no side is flat, before the next request is taken; a span step passes through
// emit, an edge-one step and edge-two steps until both edges share a row; the response
// register holds a result while the next request is processed. Reset (synchronous,
// active high) idles the block and clears the datapath, divider busy and output valid.
`default_nettype none
module triangle_span_rasterizer_core #(
   parameter int COORD_BITS = tsr_pkg::COORD_BITS_DEFAULT
) (
   input wire         clock,
   input wire         reset,
   tsr_req_if.sink    req,
   tsr_rsp_if.source  rsp
);
   import tsr_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic rsp_load, rsp_span, rsp_last, req_ready;
   logic signed [COORD_BITS-1:0] dp_y, dp_xs, dp_xe;
   logic valid_ff;
   logic signed [COORD_BITS-1:0] y_ff, xs_ff, xe_ff;
   logic span_ff, last_ff;
   logic rsp_free;

   assign rsp_free  = !valid_ff || rsp.ready;
   assign req.ready = req_ready;

   tsr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.mode),
      .req_ready (req_ready),
      .rsp_load  (rsp_load),
      .rsp_free  (rsp_free),
      .rsp_span  (rsp_span),
      .rsp_last  (rsp_last),
      .cmd       (cmd),
      .status    (status)
   );

   tsr_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .in_ax  (req.vertex_a_x),
      .in_ay  (req.vertex_a_y),
      .in_bx  (req.vertex_b_x),
      .in_by  (req.vertex_b_y),
      .in_cx  (req.vertex_c_x),
      .in_cy  (req.vertex_c_y),
      .out_y  (dp_y),
      .out_xs (dp_xs),
      .out_xe (dp_xe)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (rsp_load || rsp_span) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
      if (rsp_span) begin
         y_ff <= dp_y; xs_ff <= dp_xs; xe_ff <= dp_xe;
         span_ff <= 1'b1; last_ff <= rsp_last;
      end else if (rsp_load) begin
         y_ff <= '0; xs_ff <= '0; xe_ff <= '0;
         span_ff <= 1'b0; last_ff <= 1'b0;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.span_y       = y_ff;
   assign rsp.span_x_start = xs_ff;
   assign rsp.span_x_end   = xe_ff;
   assign rsp.span_valid   = span_ff;
   assign rsp.span_last    = last_ff;
endmodule
`default_nettype wire

FILE: sv/tsr_checker.sv
// Port-level checker for the rasterizer core and its bind statement.
`default_nettype none
module tsr_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire req_mode,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire rsp_span_valid,
   input wire rsp_span_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
   a_load_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_mode |=> rsp_valid && !rsp_span_valid)
      else $error("load did not give an empty result");
   a_last_implies_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_last |-> rsp_span_valid)
      else $error("last flag without span");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken with output full");
endmodule

bind triangle_span_rasterizer_core tsr_checker u_tsr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_mode       (req.mode),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_span_valid (rsp.span_valid),
   .rsp_span_last  (rsp.span_last)
);
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench of the triangle span rasterizer core with a built-in span predictor.
`default_nettype none

typedef struct packed {
   logic mode;
   logic signed [11:0] ax;
   logic signed [11:0] ay;
   logic signed [11:0] bx;
   logic signed [11:0] by;
   logic signed [11:0] cx;
   logic signed [11:0] cy;
} tri_req_t;

typedef struct packed {
   logic signed [11:0] y;
   logic signed [11:0] xs;
   logic signed [11:0] xe;
   logic v;
   logic l;
} span_t;

class span_scoreboard;
   int vtx[6];
   int split_x;
   int e1x, e1y, e2x, e2y;
   int maj[2], mnr[2], err[2], sx[2], sy[2], sw[2];
   int spans_done;
   tsr_pkg::phase_type phase = tsr_pkg::PH_IDLE;
   span_t spans_due[$];
   int errors;
   int loads, spans, splits;

   function void setup_edge(int k, int ax, int ay, int bx, int by);
      int dx, dy;
      dx = bx - ax;
      dy = by - ay;
      sx[k] = (dx > 0) - (dx < 0);
      sy[k] = (dy > 0) - (dy < 0);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sw[k] = dy > dx;
      maj[k] = sw[k] ? dy : dx;
      mnr[k] = sw[k] ? dx : dy;
      err[k] = 2 * mnr[k] - maj[k];
   endfunction

   function void setup_part(int ax, int ay, int bx, int by, int cx, int cy);
      e1x = ax; e1y = ay; e2x = ax; e2y = ay;
      setup_edge(0, ax, ay, bx, by);
      setup_edge(1, ax, ay, cx, cy);
      spans_done = 0;
   endfunction

   function void walk(int k, inout int x, inout int y);
      if (err[k] >= 0) begin
         if (sw[k]) x += sx[k]; else y += sy[k];
         err[k] -= 2 * maj[k];
      end
      if (sw[k]) y += sy[k]; else x += sx[k];
      err[k] += 2 * mnr[k];
   endfunction

   function void swap_vtx(int i, int j);
      int tx, ty;
      tx = vtx[2*i]; ty = vtx[2*i+1];
      vtx[2*i] = vtx[2*j]; vtx[2*i+1] = vtx[2*j+1];
      vtx[2*j] = tx; vtx[2*j+1] = ty;
   endfunction

   // Notes an accepted request and returns whether it ends a triangle or finds none active.
   function bit note(tri_req_t it);
      span_t s;
      longint den, num;
      int n;
      s = '0;
      note = 0;
      if (it.mode == 1'b0) begin
         loads++;
         vtx[0] = it.ax; vtx[1] = it.ay; vtx[2] = it.bx;
         vtx[3] = it.by; vtx[4] = it.cx; vtx[5] = it.cy;
         if (vtx[1] > vtx[3]) swap_vtx(0, 1);
         if (vtx[1] > vtx[5]) swap_vtx(0, 2);
         if (vtx[3] > vtx[5]) swap_vtx(1, 2);
         split_x = 0;
         if (vtx[3] == vtx[5]) begin
            setup_part(vtx[0], vtx[1], vtx[2], vtx[3], vtx[4], vtx[5]);
            phase = tsr_pkg::PH_FINAL;
         end else if (vtx[1] == vtx[3]) begin
            setup_part(vtx[4], vtx[5], vtx[0], vtx[1], vtx[2], vtx[3]);
            phase = tsr_pkg::PH_FINAL;
         end else begin
            splits++;
            den = longint'(vtx[5]) - vtx[1];
            num = longint'(vtx[0]) * den
                  + (longint'(vtx[3]) - vtx[1]) * (longint'(vtx[4]) - vtx[0]);
            split_x = int'(num / den);
            setup_part(vtx[0], vtx[1], vtx[2], vtx[3], split_x, vtx[3]);
            phase = tsr_pkg::PH_FIRST;
         end
      end else if (phase != tsr_pkg::PH_IDLE) begin
         spans++;
         s.y = e1y[11:0];
         s.xs = e1x[11:0];
         s.xe = e2x[11:0];
         s.v = 1'b1;
         s.l = (phase == tsr_pkg::PH_FINAL) && (spans_done >= maj[0]);
         note = s.l;
         if (spans_done >= maj[0]) begin
            if (phase == tsr_pkg::PH_FIRST) begin
               setup_part(vtx[4], vtx[5], vtx[2], vtx[3], split_x, vtx[3]);
               phase = tsr_pkg::PH_FINAL;
            end else begin
               phase = tsr_pkg::PH_IDLE;
            end
         end else begin
            n = 0;
            walk(0, e1x, e1y);
            while (e2y != e1y && n < (1 << 14)) begin
               walk(1, e2x, e2y);
               n++;
            end
            spans_done++;
         end
      end else begin
         note = 1;
      end
      spans_due.push_back(s);
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check(span_t got);
      span_t want;
      if (spans_due.size() == 0) begin
         report("response transfer with no request outstanding");
      end else begin
         want = spans_due.pop_front();
         if (got.y !== want.y) report($sformatf("span_y %0d, want %0d", got.y, want.y));
         if (got.xs !== want.xs)
            report($sformatf("span_x_start %0d, want %0d", got.xs, want.xs));
         if (got.xe !== want.xe)
            report($sformatf("span_x_end %0d, want %0d", got.xe, want.xe));
         if (got.v !== want.v) report($sformatf("span_valid %b, want %b", got.v, want.v));
         if (got.l !== want.l) report($sformatf("span_last %b, want %b", got.l, want.l));
      end
   endtask
endclass

module tb_top;
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;
   localparam int STALL_LIMIT = 30000;

   logic clock;
   logic reset;
   tsr_req_if #(12) req_if();
   tsr_rsp_if #(12) rsp_if();

   triangle_span_rasterizer_core #(.COORD_BITS(12)) DUT (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   span_scoreboard spans_sb;
   int tx_idle_pct;
   int rx_idle_pct;
   bit hold_request;
   int hold_left;
   int quiet_cycles;
   int sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      spans_sb = new();
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.mode = MODE_STEP;
      req_if.vertex_a_x = '0;
      req_if.vertex_a_y = '0;
      req_if.vertex_b_x = '0;
      req_if.vertex_b_y = '0;
      req_if.vertex_c_x = '0;
      req_if.vertex_c_y = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         spans_sb.check({rsp_if.span_y, rsp_if.span_x_start, rsp_if.span_x_end,
                         rsp_if.span_valid, rsp_if.span_last});
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("** triangle_span_rasterizer_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send(input tri_req_t it, output bit ends);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= it.mode;
      req_if.vertex_a_x <= it.ax;
      req_if.vertex_a_y <= it.ay;
      req_if.vertex_b_x <= it.bx;
      req_if.vertex_b_y <= it.by;
      req_if.vertex_c_x <= it.cx;
      req_if.vertex_c_y <= it.cy;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      ends = spans_sb.note(it);
      sent++;
   endtask

   task automatic load(input int ax, ay, bx, by, cx, cy);
      tri_req_t it;
      bit ends;
      it = {MODE_LOAD, ax[11:0], ay[11:0], bx[11:0], by[11:0], cx[11:0], cy[11:0]};
      send(it, ends);
   endtask

   task automatic step_n(input int count, output bit ends);
      tri_req_t it;
      ends = 0;
      for (int i = 0; i < count && !ends; i++) begin
         it = $bits(tri_req_t)'({$urandom, $urandom, $urandom});
         it.mode = MODE_STEP;
         send(it, ends);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (spans_sb.spans_due.size() != 0) @(posedge clock);
   endtask

   task automatic random_triangle();
      int c[6];
      int sz, bx, by, steps;
      bit ends;
      if ($urandom_range(99) < 6) begin
         foreach (c[i]) c[i] = $urandom_range(4095) - 2048;
         steps = $urandom_range(6);
      end else begin
         sz = $urandom_range(99) < 20 ? 40 : 10;
         bx = $urandom_range(4095 - sz) - 2048;
         by = $urandom_range(4095 - sz) - 2048;
         foreach (c[i]) c[i] = (i % 2 ? by : bx) + $urandom_range(sz);
         if ($urandom_range(9) == 0) c[3] = c[5];
         else if ($urandom_range(9) == 0) c[1] = c[3];
         steps = $urandom_range(99) < 85 ? 1000 : $urandom_range(8);
      end
      load(c[0], c[1], c[2], c[3], c[4], c[5]);
      step_n(steps, ends);
   endtask

   initial begin
      bit ends;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_request = 1'b0;
      hold_left = 0;
      quiet_cycles = 0;
      sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: idle steps, flat cases, degenerate and extreme triangles.
      step_n(2, ends);
      load(0, 0, 6, 4, -3, 4);
      step_n(20, ends);
      load(-5, 7, 5, 7, 0, 0);
      step_n(20, ends);
      load(3, 3, -4, 3, 9, 3);
      step_n(20, ends);
      load(2, 2, 2, 2, 2, 2);
      step_n(3, ends);
      load(-2048, -2048, 2047, 2047, -2048, 2047);
      step_n(3, ends);
      load(2047, -2048, -2048, 0, 2047, 2047);
      step_n(2, ends);
      load(0, 0, 9, 5, 1, 12);
      step_n(40, ends);
      drain();

      // Receiver holds off while the sender keeps offering steps.
      load(-20, -20, 15, 0, -8, 25);
      hold_request = 1'b1;
      step_n(1000, ends);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = ph == 0 ? 25 : (ph == 1 ? 48 : 0);
         rx_idle_pct = ph == 0 ? 48 : (ph == 1 ? 25 : 0);
         while (sent < 60 + 320 * (ph + 1)) random_triangle();
      end
      drain();
      repeat (40) @(posedge clock);

      $display("Covered %0d requests: %0d loads (%0d split), %0d spans, three idling mixes.",
               sent, spans_sb.loads, spans_sb.splits, spans_sb.spans);
      if (spans_sb.errors == 0) begin
         $display("** triangle_span_rasterizer_core: PASSED **");
      end else begin
         $display("** triangle_span_rasterizer_core: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
sv/tsr_pkg.sv
sv/tsr_if.sv
sv/tsr_divider.sv
sv/tsr_datapath.sv
sv/tsr_controller.sv
sv/triangle_span_rasterizer_core.sv
sv/tsr_checker.sv
test/tb_top.sv
